// File: design/joystick_command_line_parser_unit_macros.svh
// Assertion macros for the joystick command line parser.
`ifndef JOYSTICK_COMMAND_LINE_PARSER_UNIT_MACROS_SVH
`define JOYSTICK_COMMAND_LINE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define JCLP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JCLP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/jclp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jclp_pkg;

	localparam int VALUE_BITS_DEF   = 16;
	localparam int BUTTON_COUNT_DEF = 5;
	localparam int OUT_VALUE_BITS   = 16;
	localparam int BUTTON_BITS      = 4;
	localparam int BUTTON_OUTS      = 5;
	localparam int CHAR_BITS        = 8;
	localparam int RESULT_DATA_BITS = 2 * OUT_VALUE_BITS + BUTTON_OUTS * BUTTON_BITS;
	localparam int TDATA_BITS       = ((RESULT_DATA_BITS + 7) / 8) * 8;

	localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_BITS-1:0] CHAR_COMMA   = 8'h2C;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
	localparam logic [CHAR_BITS-1:0] CHAR_PLUS    = 8'h2B;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'h09;
	localparam logic [CHAR_BITS-1:0] CHAR_CR      = 8'h0D;
	localparam logic [CHAR_BITS-1:0] CHAR_VT      = 8'h0B;
	localparam logic [CHAR_BITS-1:0] CHAR_FF      = 8'h0C;

	// number phase
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_SKIP   = 2'd3;

	// field position
	localparam logic [1:0] FLD_X       = 2'd0;
	localparam logic [1:0] FLD_Y       = 2'd1;
	localparam logic [1:0] FLD_BUTTONS = 2'd2;

	typedef logic [BUTTON_BITS-1:0] button_t;

	typedef struct packed {
		logic                                line_error;
		logic [BUTTON_OUTS-1:0][BUTTON_BITS-1:0] buttons;
		logic [OUT_VALUE_BITS-1:0]           y_value;
		logic [OUT_VALUE_BITS-1:0]           x_value;
	} result_t;

	function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
			(c == CHAR_VT) || (c == CHAR_FF);
	endfunction

endpackage

`default_nettype wire

// File: design/jclp_number.sv
`timescale 1ns / 1ps
`default_nettype none

module jclp_number #(
	parameter int VALUE_BITS = jclp_pkg::VALUE_BITS_DEF
) (
	input  wire logic [jclp_pkg::CHAR_BITS-1:0] rx_byte,
	input  wire logic [1:0]                     phase,
	input  wire logic                           negative,
	input  wire logic [VALUE_BITS-1:0]          acc,
	output logic      [1:0]                     phase_next,
	output logic                                negative_next,
	output logic      [VALUE_BITS-1:0]          acc_next,
	output logic      [VALUE_BITS-1:0]          value
);
	import jclp_pkg::*;

	localparam logic [VALUE_BITS-1:0] MAG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] MAG_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic [VALUE_BITS+2:0] acc_times_ten;
	logic                  at_start;

	// acc*10 + digit; the digit is the low nibble of an ASCII digit
	assign acc_times_ten = {acc, 3'b000} + {2'b00, acc, 1'b0} +
		{{(VALUE_BITS-1){1'b0}}, rx_byte[3:0]};
	assign at_start = (phase == PH_START);

	always_comb begin
		phase_next    = phase;
		negative_next = negative;
		acc_next      = acc;
		if (at_start && rx_byte == CHAR_PLUS) begin
			phase_next = PH_SIGN;
		end else if (at_start && rx_byte == CHAR_MINUS) begin
			phase_next    = PH_SIGN;
			negative_next = 1'b1;
		end else if (!(at_start && is_blank(rx_byte)) && phase != PH_SKIP) begin
			if (!is_digit(rx_byte)) begin
				phase_next = PH_SKIP;
			end else begin
				phase_next = PH_DIGITS;
				if (acc_times_ten > {3'b000, MAG_LIMIT}) begin
					acc_next = MAG_LIMIT;
				end else begin
					acc_next = acc_times_ten[VALUE_BITS-1:0];
				end
			end
		end
	end

	// saturated signed value of the number parsed so far
	always_comb begin
		if (negative) begin
			value = {VALUE_BITS{1'b0}} - acc;
		end else if (acc > MAG_MAX) begin
			value = MAG_MAX;
		end else begin
			value = acc;
		end
	end

endmodule

`default_nettype wire

// File: design/jclp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module jclp_parser #(
	parameter int VALUE_BITS   = jclp_pkg::VALUE_BITS_DEF,
	parameter int BUTTON_COUNT = jclp_pkg::BUTTON_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [jclp_pkg::CHAR_BITS-1:0] rx_byte,
	output jclp_pkg::result_t                   result
);
	import jclp_pkg::*;

	localparam int CNT_BITS = $clog2(BUTTON_COUNT + 1);

	logic [1:0]              field_q;
	logic [1:0]              phase_q;
	logic                    negative_q;
	logic [VALUE_BITS-1:0]   acc_q;
	logic [VALUE_BITS-1:0]   first_q;
	logic [VALUE_BITS-1:0]   second_q;
	logic [CNT_BITS-1:0]     count_q;
	button_t                 store_q [BUTTON_COUNT];
	logic                    error_q;

	logic [1:0]              phase_next;
	logic                    negative_next;
	logic [VALUE_BITS-1:0]   acc_next;
	logic [VALUE_BITS-1:0]   num_value;
	logic [VALUE_BITS-1:0]   x_full;
	logic [VALUE_BITS-1:0]   y_full;
	logic                    buttons_short;
	logic                    rx_digit;

	jclp_number #(
		.VALUE_BITS(VALUE_BITS)
	) u_number (
		.rx_byte      (rx_byte),
		.phase        (phase_q),
		.negative     (negative_q),
		.acc          (acc_q),
		.phase_next   (phase_next),
		.negative_next(negative_next),
		.acc_next     (acc_next),
		.value        (num_value)
	);

	assign buttons_short = (count_q < CNT_BITS'(BUTTON_COUNT));
	assign rx_digit      = is_digit(rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= FLD_X;
			phase_q    <= PH_START;
			negative_q <= 1'b0;
			acc_q      <= '0;
			first_q    <= '0;
			second_q   <= '0;
			count_q    <= '0;
			error_q    <= 1'b0;
			for (int k = 0; k < BUTTON_COUNT; k++) begin
				store_q[k] <= '0;
			end
		end else if (step) begin
			if (rx_byte == CHAR_NEWLINE) begin
				field_q    <= FLD_X;
				phase_q    <= PH_START;
				negative_q <= 1'b0;
				acc_q      <= '0;
				first_q    <= '0;
				second_q   <= '0;
				count_q    <= '0;
				error_q    <= 1'b0;
				for (int k = 0; k < BUTTON_COUNT; k++) begin
					store_q[k] <= '0;
				end
			end else if (field_q != FLD_BUTTONS) begin
				if (rx_byte == CHAR_COMMA) begin
					if (field_q == FLD_X) begin
						first_q <= num_value;
					end else begin
						second_q <= num_value;
					end
					field_q    <= field_q + 2'd1;
					phase_q    <= PH_START;
					negative_q <= 1'b0;
					acc_q      <= '0;
				end else begin
					phase_q    <= phase_next;
					negative_q <= negative_next;
					acc_q      <= acc_next;
				end
			end else if (buttons_short) begin
				for (int k = 0; k < BUTTON_COUNT; k++) begin
					if (count_q == CNT_BITS'(k)) begin
						store_q[k] <= rx_digit ? rx_byte[BUTTON_BITS-1:0] : '0;
					end
				end
				if (!rx_digit) begin
					error_q <= 1'b1;
				end
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		case (field_q)
			FLD_X: begin
				x_full = num_value;
				y_full = '0;
			end
			FLD_Y: begin
				x_full = first_q;
				y_full = num_value;
			end
			default: begin
				x_full = first_q;
				y_full = second_q;
			end
		endcase
	end

	assign result.line_error = (field_q != FLD_BUTTONS) || error_q || buttons_short;

	generate
		if (VALUE_BITS >= OUT_VALUE_BITS) begin : g_trunc
			assign result.x_value = x_full[OUT_VALUE_BITS-1:0];
			assign result.y_value = y_full[OUT_VALUE_BITS-1:0];
		end else begin : g_ext
			assign result.x_value = {{(OUT_VALUE_BITS-VALUE_BITS){1'b0}}, x_full};
			assign result.y_value = {{(OUT_VALUE_BITS-VALUE_BITS){1'b0}}, y_full};
		end

		for (genvar i = 0; i < BUTTON_OUTS; i++) begin : g_btn
			if (i < BUTTON_COUNT) begin : g_used
				assign result.buttons[i] = (field_q == FLD_BUTTONS) ? store_q[i] : '0;
			end else begin : g_unused
				assign result.buttons[i] = '0;
			end
		end
	endgenerate

endmodule

`default_nettype wire

// File: design/joystick_command_line_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Parses x,y,bbbbb lines from a byte stream, one byte per beat on s_*, and
// delivers one result beat on m_* for each newline. A byte is taken every
// cycle unless a held newline fills the input register; the parser state
// updates from the byte in the input register, and a newline then loads
// the output register. Only a newline can be held back, and only while
// the output register is full and not taken; the bytes behind it wait
// then, and otherwise flow at one per cycle regardless of m_tready.
module joystick_command_line_parser_unit #(
	parameter int VALUE_BITS   = jclp_pkg::VALUE_BITS_DEF,
	parameter int BUTTON_COUNT = jclp_pkg::BUTTON_COUNT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [jclp_pkg::CHAR_BITS-1:0]  s_tdata,  // rx_byte
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// x_value, y_value, select_button, button_three, button_four,
	// button_five, button_six, zero pad
	output logic      [jclp_pkg::TDATA_BITS-1:0] m_tdata,
	output logic      [0:0]                      m_tuser   // line_error
);
	import jclp_pkg::*;

	logic                 valid_s1;
	logic [CHAR_BITS-1:0] byte_s1;
	logic                 out_valid_q;
	result_t              result_q;
	result_t              result;
	logic                 out_free;
	logic                 advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (out_free || byte_s1 != CHAR_NEWLINE);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	jclp_parser #(
		.VALUE_BITS  (VALUE_BITS),
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(byte_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && byte_s1 == CHAR_NEWLINE) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && byte_s1 == CHAR_NEWLINE) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_BITS - RESULT_DATA_BITS){1'b0}},
		result_q.buttons, result_q.y_value, result_q.x_value};
	assign m_tuser  = result_q.line_error;

endmodule

`default_nettype wire

// File: design/jclp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_command_line_parser_unit_macros.svh"

module jclp_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [jclp_pkg::CHAR_BITS-1:0]  s_tdata,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [jclp_pkg::TDATA_BITS-1:0] m_tdata,
	input wire logic [0:0]                      m_tuser
);
	import jclp_pkg::*;

	logic s_beat;
	assign s_beat = s_tvalid && s_tready && (s_tdata == CHAR_NEWLINE);

	// a stalled result beat holds
	`JCLP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

	// button fields are always decimal digits
	`JCLP_ASSERT_NOW(a_btn_digit, clk, arst_n, m_tvalid, (m_tdata[35:32] <= 4'd9) && (m_tdata[39:36] <= 4'd9) && (m_tdata[43:40] <= 4'd9) && (m_tdata[47:44] <= 4'd9) && (m_tdata[51:48] <= 4'd9), "button field above nine")

	// input never stalls while the output register is empty
	`JCLP_ASSERT_NOW(a_in_ready, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty output")

	// an accepted newline with a free output leads to a result
	`JCLP_ASSERT_NEXT(a_nl_result, clk, arst_n, s_beat && !m_tvalid, ##1 m_tvalid, "newline gave no result")

endmodule

bind joystick_command_line_parser_unit jclp_checker u_jclp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
